// File: src/dpw_pkg.sv
// ----------------------------------------------------------------------------
// dpw_pkg
// widths, register map and reset values for the depth pixel to world point block
// ----------------------------------------------------------------------------
package dpw_pkg;

	// input field widths
	localparam int COORD_BITS = 12;
	localparam int DEPTH_BITS = 16;
	localparam int COLOUR_W   = 8;
	localparam int FRAC_BITS  = 4;

	// register widths
	localparam int CENTER_W = 16;
	localparam int INV_W    = 32;
	localparam int QUAT_W   = 64;
	localparam int QC_W     = 16;
	localparam int SHIFT_W  = 32;

	// result field width
	localparam int OUT_W = 40;

	// stream payload widths
	localparam int IN_TW  = 2 * COORD_BITS + DEPTH_BITS + 3 * COLOUR_W;
	localparam int OUT_TW = 3 * OUT_W + 3 * COLOUR_W;

	// configuration port
	localparam int NUM_REGS = 8;
	localparam int IDX_W    = 3;
	localparam int ADDR_W   = IDX_W + 3;
	localparam int DATA_W   = 64;

	localparam logic [IDX_W-1:0] REG_CENTER_COL    = 3'd0;
	localparam logic [IDX_W-1:0] REG_CENTER_ROW    = 3'd1;
	localparam logic [IDX_W-1:0] REG_INV_FOCAL_COL = 3'd2;
	localparam logic [IDX_W-1:0] REG_INV_FOCAL_ROW = 3'd3;
	localparam logic [IDX_W-1:0] REG_POSE_QUAT    = 3'd4;
	localparam logic [IDX_W-1:0] REG_SHIFT_X       = 3'd5;
	localparam logic [IDX_W-1:0] REG_SHIFT_Y       = 3'd6;
	localparam logic [IDX_W-1:0] REG_SHIFT_Z       = 3'd7;

	localparam logic [CENTER_W-1:0] RST_CENTER_COL = 16'd5208;
	localparam logic [CENTER_W-1:0] RST_CENTER_ROW = 16'd4056;
	localparam logic [INV_W-1:0]    RST_INV_COL    = 32'd8291443;
	localparam logic [INV_W-1:0]    RST_INV_ROW    = 32'd8275467;
	localparam logic [QUAT_W-1:0]   RST_POSE_QUAT  = 64'h4000_0000_0000_0000;

	// back-projection datapath
	localparam int PIX_W  = COORD_BITS + FRAC_BITS;
	localparam int MAG_W  = (PIX_W > CENTER_W) ? PIX_W : CENTER_W;
	localparam int M_W    = MAG_W + DEPTH_BITS;
	localparam int PROD_W = M_W + INV_W;
	localparam int P_W    = M_W + 1;
	localparam int PZ_W   = DEPTH_BITS + FRAC_BITS;

	// rotation datapath, matrix entries in Q.28
	localparam int QP_W      = 2 * QC_W;
	localparam int ROT_W     = 2 * QC_W + 2;
	localparam int ROT_SHIFT = 28;
	localparam int PLO_W     = 17;
	localparam int PHI_W     = P_W - PLO_W;
	localparam int PPH_W     = ROT_W + PHI_W;
	localparam int PPL_W     = ROT_W + PLO_W + 1;
	localparam int SUMH_W    = PPH_W + 2;
	localparam int SUML_W    = PPL_W + 2;
	localparam int TOT_W     = ROT_W + P_W + 2;
	localparam int RES_W     = TOT_W - ROT_SHIFT;
	localparam int WSUM_W    = ((RES_W > SHIFT_W) ? RES_W : SHIFT_W) + 1;

endpackage

// File: src/depth_pixel_to_world_point.sv
// ----------------------------------------------------------------------------
// depth_pixel_to_world_point
// pinhole back-projection of depth pixels followed by a rigid pose transform
// ----------------------------------------------------------------------------
// throughput: one pixel per cycle, eight register stages, stalls only on m_tready
// zero-depth pixels are accepted and dropped at the first stage
// rotation matrix follows the quaternion register through two register stages
// reset empties the pipeline and restores the register defaults
module depth_pixel_to_world_point (
	input  logic                           clk,
	input  logic                           arst_n,
	// apb configuration
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [dpw_pkg::ADDR_W-1:0]     paddr,
	input  logic [dpw_pkg::DATA_W-1:0]     pwdata,
	output logic [dpw_pkg::DATA_W-1:0]     prdata,
	output logic                           pready,
	// pixel stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [dpw_pkg::IN_TW-1:0]      s_tdata,   // col, row, depth_raw, red, green, blue
	// point stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [dpw_pkg::OUT_TW-1:0]     m_tdata    // world_x, world_y, world_z, red, green, blue
);

	localparam int CB = dpw_pkg::COORD_BITS;
	localparam int DB = dpw_pkg::DEPTH_BITS;
	localparam int RGB_W = 3 * dpw_pkg::COLOUR_W;

	// ------------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------------
	logic [dpw_pkg::CENTER_W-1:0]      center_col_q, center_row_q;
	logic [dpw_pkg::INV_W-1:0]         inv_col_q, inv_row_q;
	logic [dpw_pkg::QUAT_W-1:0]        pose_q;
	logic signed [dpw_pkg::SHIFT_W-1:0] shift_q [3];

	logic                    cfg_wr;
	logic [dpw_pkg::IDX_W-1:0] cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[dpw_pkg::ADDR_W-1:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_col_q <= dpw_pkg::RST_CENTER_COL;
			center_row_q <= dpw_pkg::RST_CENTER_ROW;
			inv_col_q    <= dpw_pkg::RST_INV_COL;
			inv_row_q    <= dpw_pkg::RST_INV_ROW;
			pose_q       <= dpw_pkg::RST_POSE_QUAT;
			shift_q[0]   <= '0;
			shift_q[1]   <= '0;
			shift_q[2]   <= '0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				dpw_pkg::REG_CENTER_COL:    center_col_q <= pwdata[dpw_pkg::CENTER_W-1:0];
				dpw_pkg::REG_CENTER_ROW:    center_row_q <= pwdata[dpw_pkg::CENTER_W-1:0];
				dpw_pkg::REG_INV_FOCAL_COL: inv_col_q    <= pwdata[dpw_pkg::INV_W-1:0];
				dpw_pkg::REG_INV_FOCAL_ROW: inv_row_q    <= pwdata[dpw_pkg::INV_W-1:0];
				dpw_pkg::REG_POSE_QUAT:    pose_q       <= pwdata[dpw_pkg::QUAT_W-1:0];
				dpw_pkg::REG_SHIFT_X:       shift_q[0]   <= pwdata[dpw_pkg::SHIFT_W-1:0];
				dpw_pkg::REG_SHIFT_Y:       shift_q[1]   <= pwdata[dpw_pkg::SHIFT_W-1:0];
				dpw_pkg::REG_SHIFT_Z:       shift_q[2]   <= pwdata[dpw_pkg::SHIFT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			dpw_pkg::REG_CENTER_COL:    prdata = dpw_pkg::DATA_W'(center_col_q);
			dpw_pkg::REG_CENTER_ROW:    prdata = dpw_pkg::DATA_W'(center_row_q);
			dpw_pkg::REG_INV_FOCAL_COL: prdata = dpw_pkg::DATA_W'(inv_col_q);
			dpw_pkg::REG_INV_FOCAL_ROW: prdata = dpw_pkg::DATA_W'(inv_row_q);
			dpw_pkg::REG_POSE_QUAT:    prdata = dpw_pkg::DATA_W'(pose_q);
			dpw_pkg::REG_SHIFT_X:       prdata = dpw_pkg::DATA_W'(unsigned'(shift_q[0]));
			dpw_pkg::REG_SHIFT_Y:       prdata = dpw_pkg::DATA_W'(unsigned'(shift_q[1]));
			dpw_pkg::REG_SHIFT_Z:       prdata = dpw_pkg::DATA_W'(unsigned'(shift_q[2]));
			default:                    prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------------
	// rotation matrix from the quaternion, Q.28
	// ------------------------------------------------------------------------
	logic signed [dpw_pkg::QC_W-1:0] qw, qx, qy, qz;
	logic signed [dpw_pkg::QP_W-1:0] xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;
	logic signed [dpw_pkg::ROT_W-1:0] rot_q [9];
	logic signed [dpw_pkg::ROT_W-1:0] rot_one;

	assign qw = pose_q[4*dpw_pkg::QC_W-1:3*dpw_pkg::QC_W];
	assign qx = pose_q[3*dpw_pkg::QC_W-1:2*dpw_pkg::QC_W];
	assign qy = pose_q[2*dpw_pkg::QC_W-1:dpw_pkg::QC_W];
	assign qz = pose_q[dpw_pkg::QC_W-1:0];
	assign rot_one = dpw_pkg::ROT_W'(1) <<< dpw_pkg::ROT_SHIFT;

	always_ff @(posedge clk) begin
		xx_q <= dpw_pkg::QP_W'(qx) * dpw_pkg::QP_W'(qx);
		yy_q <= dpw_pkg::QP_W'(qy) * dpw_pkg::QP_W'(qy);
		zz_q <= dpw_pkg::QP_W'(qz) * dpw_pkg::QP_W'(qz);
		xy_q <= dpw_pkg::QP_W'(qx) * dpw_pkg::QP_W'(qy);
		xz_q <= dpw_pkg::QP_W'(qx) * dpw_pkg::QP_W'(qz);
		yz_q <= dpw_pkg::QP_W'(qy) * dpw_pkg::QP_W'(qz);
		wx_q <= dpw_pkg::QP_W'(qw) * dpw_pkg::QP_W'(qx);
		wy_q <= dpw_pkg::QP_W'(qw) * dpw_pkg::QP_W'(qy);
		wz_q <= dpw_pkg::QP_W'(qw) * dpw_pkg::QP_W'(qz);

		rot_q[0] <= rot_one - ((dpw_pkg::ROT_W'(yy_q) + dpw_pkg::ROT_W'(zz_q)) <<< 1);
		rot_q[1] <= (dpw_pkg::ROT_W'(xy_q) - dpw_pkg::ROT_W'(wz_q)) <<< 1;
		rot_q[2] <= (dpw_pkg::ROT_W'(xz_q) + dpw_pkg::ROT_W'(wy_q)) <<< 1;
		rot_q[3] <= (dpw_pkg::ROT_W'(xy_q) + dpw_pkg::ROT_W'(wz_q)) <<< 1;
		rot_q[4] <= rot_one - ((dpw_pkg::ROT_W'(xx_q) + dpw_pkg::ROT_W'(zz_q)) <<< 1);
		rot_q[5] <= (dpw_pkg::ROT_W'(yz_q) - dpw_pkg::ROT_W'(wx_q)) <<< 1;
		rot_q[6] <= (dpw_pkg::ROT_W'(xz_q) - dpw_pkg::ROT_W'(wy_q)) <<< 1;
		rot_q[7] <= (dpw_pkg::ROT_W'(yz_q) + dpw_pkg::ROT_W'(wx_q)) <<< 1;
		rot_q[8] <= rot_one - ((dpw_pkg::ROT_W'(xx_q) + dpw_pkg::ROT_W'(yy_q)) <<< 1);
	end

	// ------------------------------------------------------------------------
	// pipeline control
	// ------------------------------------------------------------------------
	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic in_xfer;

	logic [CB-1:0]    in_col, in_row;
	logic [DB-1:0]    in_depth;
	logic [RGB_W-1:0] in_rgb;

	assign in_col   = s_tdata[CB-1:0];
	assign in_row   = s_tdata[2*CB-1:CB];
	assign in_depth = s_tdata[2*CB+DB-1:2*CB];
	assign in_rgb   = s_tdata[2*CB+DB+RGB_W-1:2*CB+DB];

	assign en       = !v_s8 || m_tready;
	assign s_tready = en;
	assign m_tvalid = v_s8;
	assign in_xfer  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid && (in_depth != '0);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// ------------------------------------------------------------------------
	// stage 1: offset from the principal point, magnitude and sign
	// ------------------------------------------------------------------------
	logic [dpw_pkg::MAG_W:0] dx, dy;
	logic [dpw_pkg::MAG_W-1:0] magx_s1, magy_s1;
	logic negx_s1, negy_s1;
	logic [DB-1:0] d_s1;
	logic [RGB_W-1:0] rgb_s1;

	assign dx = (dpw_pkg::MAG_W+1)'({in_col, dpw_pkg::FRAC_BITS'(0)})
		- (dpw_pkg::MAG_W+1)'(center_col_q);
	assign dy = (dpw_pkg::MAG_W+1)'({in_row, dpw_pkg::FRAC_BITS'(0)})
		- (dpw_pkg::MAG_W+1)'(center_row_q);

	always_ff @(posedge clk) begin
		if (en) begin
			negx_s1 <= dx[dpw_pkg::MAG_W];
			negy_s1 <= dy[dpw_pkg::MAG_W];
			magx_s1 <= dx[dpw_pkg::MAG_W] ? -dx[dpw_pkg::MAG_W-1:0] : dx[dpw_pkg::MAG_W-1:0];
			magy_s1 <= dy[dpw_pkg::MAG_W] ? -dy[dpw_pkg::MAG_W-1:0] : dy[dpw_pkg::MAG_W-1:0];
			d_s1    <= in_depth;
			rgb_s1  <= in_rgb;
		end
	end

	// ------------------------------------------------------------------------
	// stage 2: offset times depth
	// ------------------------------------------------------------------------
	logic [dpw_pkg::M_W-1:0] mx_s2, my_s2;
	logic negx_s2, negy_s2;
	logic [DB-1:0] d_s2;
	logic [RGB_W-1:0] rgb_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s2   <= dpw_pkg::M_W'(magx_s1) * dpw_pkg::M_W'(d_s1);
			my_s2   <= dpw_pkg::M_W'(magy_s1) * dpw_pkg::M_W'(d_s1);
			negx_s2 <= negx_s1;
			negy_s2 <= negy_s1;
			d_s2    <= d_s1;
			rgb_s2  <= rgb_s1;
		end
	end

	// ------------------------------------------------------------------------
	// stage 3: times the reciprocal focal length
	// ------------------------------------------------------------------------
	logic [dpw_pkg::PROD_W-1:0] prx_s3, pry_s3;
	logic negx_s3, negy_s3;
	logic [DB-1:0] d_s3;
	logic [RGB_W-1:0] rgb_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			prx_s3  <= dpw_pkg::PROD_W'(mx_s2) * dpw_pkg::PROD_W'(inv_col_q);
			pry_s3  <= dpw_pkg::PROD_W'(my_s2) * dpw_pkg::PROD_W'(inv_row_q);
			negx_s3 <= negx_s2;
			negy_s3 <= negy_s2;
			d_s3    <= d_s2;
			rgb_s3  <= rgb_s2;
		end
	end

	// ------------------------------------------------------------------------
	// stage 4: round half away from zero, apply sign
	// ------------------------------------------------------------------------
	logic [dpw_pkg::PROD_W-1:0] rndx, rndy;
	logic [dpw_pkg::P_W-1:0]    rx, ry;
	logic signed [dpw_pkg::P_W-1:0] px_s4, py_s4;
	logic [dpw_pkg::PZ_W-1:0] pz_s4;
	logic [RGB_W-1:0] rgb_s4;

	assign rndx = prx_s3 + (dpw_pkg::PROD_W'(1) << (dpw_pkg::INV_W - 1));
	assign rndy = pry_s3 + (dpw_pkg::PROD_W'(1) << (dpw_pkg::INV_W - 1));
	assign rx   = dpw_pkg::P_W'(rndx[dpw_pkg::PROD_W-1:dpw_pkg::INV_W]);
	assign ry   = dpw_pkg::P_W'(rndy[dpw_pkg::PROD_W-1:dpw_pkg::INV_W]);

	always_ff @(posedge clk) begin
		if (en) begin
			px_s4  <= negx_s3 ? -rx : rx;
			py_s4  <= negy_s3 ? -ry : ry;
			pz_s4  <= {d_s3, dpw_pkg::FRAC_BITS'(0)};
			rgb_s4 <= rgb_s3;
		end
	end

	// ------------------------------------------------------------------------
	// stage 5: matrix times point, split into high and low partial products
	// ------------------------------------------------------------------------
	logic signed [dpw_pkg::P_W-1:0]   pv [3];
	logic signed [dpw_pkg::PHI_W-1:0] phi [3];
	logic signed [dpw_pkg::PLO_W:0]   plo [3];
	logic signed [dpw_pkg::PPH_W-1:0] pph_s5 [9];
	logic signed [dpw_pkg::PPL_W-1:0] ppl_s5 [9];
	logic [RGB_W-1:0] rgb_s5;

	always_comb begin
		pv[0] = px_s4;
		pv[1] = py_s4;
		pv[2] = signed'(dpw_pkg::P_W'(pz_s4));
		for (int i = 0; i < 3; i++) begin
			phi[i] = pv[i][dpw_pkg::P_W-1:dpw_pkg::PLO_W];
			plo[i] = signed'({1'b0, pv[i][dpw_pkg::PLO_W-1:0]});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				for (int i = 0; i < 3; i++) begin
					pph_s5[3*k+i] <= dpw_pkg::PPH_W'(rot_q[3*k+i]) * dpw_pkg::PPH_W'(phi[i]);
					ppl_s5[3*k+i] <= dpw_pkg::PPL_W'(rot_q[3*k+i]) * dpw_pkg::PPL_W'(plo[i]);
				end
			end
			rgb_s5 <= rgb_s4;
		end
	end

	// ------------------------------------------------------------------------
	// stage 6: row sums of the partial products
	// ------------------------------------------------------------------------
	logic signed [dpw_pkg::SUMH_W-1:0] sh_s6 [3];
	logic signed [dpw_pkg::SUML_W-1:0] sl_s6 [3];
	logic [RGB_W-1:0] rgb_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				sh_s6[k] <= dpw_pkg::SUMH_W'(pph_s5[3*k]) + dpw_pkg::SUMH_W'(pph_s5[3*k+1])
					+ dpw_pkg::SUMH_W'(pph_s5[3*k+2]);
				sl_s6[k] <= dpw_pkg::SUML_W'(ppl_s5[3*k]) + dpw_pkg::SUML_W'(ppl_s5[3*k+1])
					+ dpw_pkg::SUML_W'(ppl_s5[3*k+2]);
			end
			rgb_s6 <= rgb_s5;
		end
	end

	// ------------------------------------------------------------------------
	// stage 7: recombine and round half up out of Q.28
	// ------------------------------------------------------------------------
	logic signed [dpw_pkg::TOT_W-1:0] tot [3];
	logic signed [dpw_pkg::RES_W-1:0] res_s7 [3];
	logic [RGB_W-1:0] rgb_s7;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			tot[k] = (dpw_pkg::TOT_W'(sh_s6[k]) <<< dpw_pkg::PLO_W) + dpw_pkg::TOT_W'(sl_s6[k])
				+ (dpw_pkg::TOT_W'(1) <<< (dpw_pkg::ROT_SHIFT - 1));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				res_s7[k] <= tot[k][dpw_pkg::TOT_W-1:dpw_pkg::ROT_SHIFT];
			end
			rgb_s7 <= rgb_s6;
		end
	end

	// ------------------------------------------------------------------------
	// stage 8: translate and saturate
	// ------------------------------------------------------------------------
	logic signed [dpw_pkg::WSUM_W-1:0] wsum [3];
	logic [dpw_pkg::OUT_W-1:0] wsat [3];
	logic [dpw_pkg::OUT_W-1:0] world_s8 [3];
	logic [RGB_W-1:0] rgb_s8;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			wsum[k] = dpw_pkg::WSUM_W'(res_s7[k]) + dpw_pkg::WSUM_W'(shift_q[k]);
			if (wsum[k][dpw_pkg::WSUM_W-1:dpw_pkg::OUT_W-1] == '0
				|| wsum[k][dpw_pkg::WSUM_W-1:dpw_pkg::OUT_W-1] == '1) begin
				wsat[k] = wsum[k][dpw_pkg::OUT_W-1:0];
			end else if (wsum[k][dpw_pkg::WSUM_W-1]) begin
				wsat[k] = {1'b1, (dpw_pkg::OUT_W-1)'(0)};
			end else begin
				wsat[k] = {1'b0, {(dpw_pkg::OUT_W-1){1'b1}}};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				world_s8[k] <= wsat[k];
			end
			rgb_s8 <= rgb_s7;
		end
	end

	assign m_tdata = {rgb_s8, world_s8[2], world_s8[1], world_s8[0]};

	// ------------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------------
	a_zero_depth_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && (in_depth == '0) |=> !v_s1)
		else $error("zero-depth transaction entered the pipeline");

	a_depth_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && (in_depth != '0) |=> v_s1)
		else $error("accepted transaction lost at entry");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable({v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8}))
		else $error("pipeline valid bits moved during a stall");

	a_mid_advance: assert property (@(posedge clk) disable iff (!arst_n)
		en && v_s4 |=> v_s5)
		else $error("transaction lost between stages four and five");

endmodule
